// ===== rtl/base64_text_validator_defines.svh =====
// Assertion macros used by the top file of this block.
`ifndef BASE64_TEXT_VALIDATOR_DEFINES_SVH
`define BASE64_TEXT_VALIDATOR_DEFINES_SVH

// Checked on every clock edge outside reset.
`define B64V_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every clock edge, reset included.
`define B64V_ASSERT_ALL(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// ===== rtl/b64v_pkg.sv =====
package b64v_pkg;

    localparam int unsigned MAX_TEXT_LEN_DEF = 65535;
    localparam int unsigned MID_DEPTH = 2;
    localparam int unsigned OUT_DEPTH = 2;

    localparam logic [1:0] REG_LEN_EN = 2'd0;
    localparam logic [1:0] REG_MIN    = 2'd1;
    localparam logic [1:0] REG_MAX    = 2'd2;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_BAD   = 3'd1,
        ST_COUNT = 3'd2,
        ST_RANGE = 3'd3,
        ST_LONG  = 3'd4
    } t_status;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       last_byte;
        logic       empty_value;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [15:0] decoded_octets;
        logic [15:0] trim_start;
        logic [15:0] trim_end;
        logic [15:0] bad_offset;
    } t_result;

    typedef struct packed {
        logic ws;
        logic dat;
        logic eq;
        logic nl;
        logic last;
        logic empty;
    } t_cls;

    typedef struct packed {
        logic        too_long;
        logic        err;
        logic [15:0] ts;
        logic [15:0] te;
        logic [15:0] bad;
        logic [1:0]  pad;
    } t_sum;

    typedef struct packed {
        logic        len_en;
        logic [15:0] min_octets;
        logic [15:0] max_octets;
    } t_cfg;

endpackage

// ===== rtl/b64v_queue.sv =====
module b64v_queue #(
    parameter int unsigned W     = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wptr, n_wptr;
    logic [AW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_comb begin
        n_wptr  = do_push ? bump(r_wptr) : r_wptr;
        n_rptr  = do_pop ? bump(r_rptr) : r_rptr;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// ===== rtl/b64v_front.sv =====
module b64v_front import b64v_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_in_item i_item,
    output logic     o_full,
    input  logic     i_take,
    output t_cls     o_cls,
    output logic     o_valid
);

    localparam int unsigned CLS_W = $bits(t_cls);

    t_cls             cls;
    logic [CLS_W-1:0] q_data;
    logic             q_empty;

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, [8'h09:8'h0D]};
    endfunction

    function automatic logic is_data(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39], 8'h2B, 8'h2F};
    endfunction

    always_comb begin
        cls.ws    = is_space(i_item.text_byte);
        cls.dat   = is_data(i_item.text_byte);
        cls.eq    = (i_item.text_byte == 8'h3D);
        cls.nl    = (i_item.text_byte == 8'h0A);
        cls.last  = i_item.last_byte;
        cls.empty = i_item.empty_value;
    end

    b64v_queue #(
        .W     (CLS_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (cls),
        .o_full  (o_full),
        .i_pop   (i_take),
        .o_data  (q_data),
        .o_empty (q_empty)
    );

    assign o_cls   = t_cls'(q_data);
    assign o_valid = !q_empty;

endmodule

// ===== rtl/b64v_scan.sv =====
module b64v_scan import b64v_pkg::*; #(
    parameter int unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF,
    localparam int unsigned POS_W = $clog2(MAX_TEXT_LEN + 2),
    localparam int unsigned TOT_W = POS_W + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_cls             i_cls,
    output logic             o_take,
    output logic             o_sum_valid,
    output t_sum             o_sum,
    output logic [TOT_W-1:0] o_total,
    input  logic             i_sum_take
);

    typedef enum logic [3:0] {
        PH_LEAD = 4'b0001,
        PH_DATA = 4'b0010,
        PH_PAD  = 4'b0100,
        PH_STOP = 4'b1000
    } t_phase;

    t_phase           r_phase, n_phase, eff;
    logic [POS_W-1:0] r_data, n_data;
    logic [1:0]       r_pad, n_pad;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [15:0]      r_first, n_first;
    logic [15:0]      r_last, n_last;
    logic             r_err, n_err;
    logic [15:0]      r_erro, n_erro;
    logic             r_sum_valid;
    t_sum             r_sum, sum;
    logic [TOT_W-1:0] r_total, total;
    logic             fin, stop;

    always_comb begin
        n_phase = r_phase;
        n_data  = r_data;
        n_pad   = r_pad;
        n_pos   = r_pos;
        n_first = r_first;
        n_last  = r_last;
        n_err   = r_err;
        n_erro  = r_erro;
        eff     = r_phase;
        stop    = 1'b0;
        fin     = i_cls.last || i_cls.empty;
        o_take  = i_valid && (!fin || !r_sum_valid || i_sum_take);
        if (!i_cls.empty) begin
            if (r_pos >= POS_W'(MAX_TEXT_LEN)) begin
                n_pos = POS_W'(MAX_TEXT_LEN + 1);
            end else begin
                n_pos = r_pos + 1'b1;
                if (!i_cls.ws) begin
                    n_last = 16'(r_pos) + 16'd1;
                end
                if (r_phase == PH_LEAD && !i_cls.ws) begin
                    n_first = 16'(r_pos);
                    eff     = PH_DATA;
                    n_phase = PH_DATA;
                end
                case (eff)
                    PH_DATA: begin
                        if (i_cls.dat) begin
                            n_data = r_data + 1'b1;
                        end else if (i_cls.eq) begin
                            n_phase = PH_PAD;
                            n_pad   = 2'd1;
                        end else if (!i_cls.nl) begin
                            stop = 1'b1;
                        end
                    end
                    PH_PAD: begin
                        if (i_cls.eq && r_pad < 2'd2) begin
                            n_pad = r_pad + 2'd1;
                        end else if (!(i_cls.nl && r_pad < 2'd2)) begin
                            stop = 1'b1;
                        end
                    end
                    PH_STOP: begin
                        if (!i_cls.ws) begin
                            n_err = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                if (stop) begin
                    n_phase = PH_STOP;
                    n_erro  = 16'(r_pos);
                    if (!i_cls.ws) begin
                        n_err = 1'b1;
                    end
                end
            end
        end
        sum.too_long = (n_pos > POS_W'(MAX_TEXT_LEN));
        sum.err      = n_err;
        sum.ts       = (n_phase == PH_LEAD) ? 16'(n_pos) : n_first;
        sum.te       = (n_phase == PH_LEAD) ? 16'(n_pos) : n_last;
        sum.bad      = n_erro;
        sum.pad      = n_pad;
        total        = TOT_W'(n_data) + TOT_W'(n_pad);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_LEAD;
            r_data      <= '0;
            r_pad       <= '0;
            r_pos       <= '0;
            r_first     <= '0;
            r_last      <= '0;
            r_err       <= 1'b0;
            r_erro      <= '0;
            r_sum_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (fin) begin
                    r_phase <= PH_LEAD;
                    r_data  <= '0;
                    r_pad   <= '0;
                    r_pos   <= '0;
                    r_first <= '0;
                    r_last  <= '0;
                    r_err   <= 1'b0;
                    r_erro  <= '0;
                end else begin
                    r_phase <= n_phase;
                    r_data  <= n_data;
                    r_pad   <= n_pad;
                    r_pos   <= n_pos;
                    r_first <= n_first;
                    r_last  <= n_last;
                    r_err   <= n_err;
                    r_erro  <= n_erro;
                end
            end
            if (o_take && fin) begin
                r_sum_valid <= 1'b1;
            end else if (i_sum_take) begin
                r_sum_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && fin) begin
            r_sum   <= sum;
            r_total <= total;
        end
    end

    assign o_sum_valid = r_sum_valid;
    assign o_sum       = r_sum;
    assign o_total     = r_total;

endmodule

// ===== rtl/b64v_finish.sv =====
module b64v_finish import b64v_pkg::*; #(
    parameter int unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF,
    localparam int unsigned TOT_W = $clog2(MAX_TEXT_LEN + 2) + 1
) (
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    input  t_sum             i_sum,
    input  logic [TOT_W-1:0] i_total,
    input  logic             i_full,
    output logic             o_take,
    output logic             o_push,
    output t_result          o_result
);

    localparam int unsigned CW = (TOT_W + 1 > 17) ? TOT_W + 1 : 17;

    logic [CW-1:0] quads, dec;
    logic          out_of_range;

    always_comb begin
        quads        = CW'(i_total >> 2);
        dec          = (quads << 1) + quads - CW'(i_sum.pad);
        out_of_range = i_cfg.len_en && (dec < CW'(i_cfg.min_octets) ||
                                        dec > CW'(i_cfg.max_octets));
        if (i_sum.too_long) begin
            o_result.status = ST_LONG;
        end else if (i_sum.err) begin
            o_result.status = ST_BAD;
        end else if (i_total[1:0] != 2'd0) begin
            o_result.status = ST_COUNT;
        end else if (out_of_range) begin
            o_result.status = ST_RANGE;
        end else begin
            o_result.status = ST_OK;
        end
        if (o_result.status == ST_OK || o_result.status == ST_RANGE) begin
            o_result.decoded_octets = (dec > CW'(16'hFFFF)) ? 16'hFFFF : dec[15:0];
        end else begin
            o_result.decoded_octets = '0;
        end
        o_result.trim_start = i_sum.too_long ? '0 : i_sum.ts;
        o_result.trim_end   = i_sum.too_long ? '0 : i_sum.te;
        o_result.bad_offset = (o_result.status == ST_BAD) ? i_sum.bad : '0;
    end

    assign o_push = i_valid && !i_full;
    assign o_take = o_push;

endmodule

// ===== rtl/base64_text_validator.sv =====
// Checks a text value, one byte per beat with a last-byte mark, as base64 text and gives one
// result beat per value: status, decoded length, trimmed offsets and the first bad offset.
// The scanner updates its phase and counters once per byte, and a result passes through the
// byte queue and the scanner's summary register before it reaches the result queue. It
// sustains one input beat per clock, and takes input while results wait to be popped, until
// the two-entry byte queue fills behind a scanner held up by a full result queue. Registers
// sit at byte addresses 0 (length check enable), 4 (minimum octets) and 8 (maximum octets).
`include "base64_text_validator_defines.svh"

module base64_text_validator import b64v_pkg::*; #(
    parameter int unsigned MAX_TEXT_LEN = MAX_TEXT_LEN_DEF,
    localparam int unsigned TOT_W = $clog2(MAX_TEXT_LEN + 2) + 1
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    input  t_in_item    i_item,
    output logic        full,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned RES_W = $bits(t_result);

    t_cfg             r_cfg;
    logic             cfg_wr;
    t_cls             cls;
    logic             cls_valid, cls_take;
    t_sum             sum;
    logic             sum_valid, sum_take;
    logic [TOT_W-1:0] total;
    logic             res_push, res_full;
    t_result          res;
    logic [RES_W-1:0] out_data;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.len_en     <= 1'b0;
            r_cfg.min_octets <= 16'h0000;
            r_cfg.max_octets <= 16'hFFFF;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LEN_EN: r_cfg.len_en     <= pwdata[0];
                REG_MIN:    r_cfg.min_octets <= pwdata[15:0];
                REG_MAX:    r_cfg.max_octets <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LEN_EN: prdata = {31'd0, r_cfg.len_en};
            REG_MIN:    prdata = {16'd0, r_cfg.min_octets};
            REG_MAX:    prdata = {16'd0, r_cfg.max_octets};
            default:    prdata = '0;
        endcase
    end

    b64v_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (i_item),
        .o_full  (full),
        .i_take  (cls_take),
        .o_cls   (cls),
        .o_valid (cls_valid)
    );

    b64v_scan #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (cls_valid),
        .i_cls       (cls),
        .o_take      (cls_take),
        .o_sum_valid (sum_valid),
        .o_sum       (sum),
        .o_total     (total),
        .i_sum_take  (sum_take)
    );

    b64v_finish #(
        .MAX_TEXT_LEN (MAX_TEXT_LEN)
    ) u_finish (
        .i_cfg    (r_cfg),
        .i_valid  (sum_valid),
        .i_sum    (sum),
        .i_total  (total),
        .i_full   (res_full),
        .o_take   (sum_take),
        .o_push   (res_push),
        .o_result (res)
    );

    b64v_queue #(
        .W     (RES_W),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty)
    );

    assign o_result = t_result'(out_data);

    `B64V_ASSERT_ALL(a_rst_empty, !i_rst_n |=> empty, "Result queue not empty after reset.")
    `B64V_ASSERT(a_long_zero, !empty && o_result.status == ST_LONG |-> o_result.decoded_octets == '0 && o_result.trim_start == '0 && o_result.trim_end == '0, "Too-long result carries nonzero fields.")
    `B64V_ASSERT(a_bad_zero, !empty && o_result.status != ST_BAD |-> o_result.bad_offset == '0, "Bad offset given without a bad character.")
    `B64V_ASSERT(a_cfg_min, cfg_wr && paddr[3:2] == REG_MIN |=> r_cfg.min_octets == $past(pwdata[15:0]), "Minimum octets register write lost.")

endmodule

// ===== tb/sv/base64_text_validator_test.sv =====
`timescale 1ns / 100ps

module base64_text_validator_test;
    import b64v_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_BEATS_PER_PHASE = 125;

    localparam logic [7:0] CH_PAD   = "=";
    localparam logic [7:0] CH_PLUS  = "+";
    localparam logic [7:0] CH_SLASH = "/";
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum int {
        SCAN_LEAD,
        SCAN_DATA,
        SCAN_PAD,
        SCAN_STOP
    } t_scan_phase;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    t_in_item    i_item = '0;
    logic        full;
    logic        empty;
    logic        pop = 1'b0;
    t_result     o_result;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    base64_text_validator u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .i_item   (i_item),
        .full     (full),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_in_item    text_beats[$];
    t_result     pending_results[$];
    int unsigned beats_queued = 0;
    int unsigned beats_taken = 0;
    int unsigned mismatches = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned holds_asked = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;

    logic        cfg_len_en = 1'b0;
    logic [15:0] cfg_min = 16'd0;
    logic [15:0] cfg_max = 16'hFFFF;

    t_scan_phase scan_phase = SCAN_LEAD;
    int unsigned data_cnt = 0;
    int unsigned pad_cnt = 0;
    int unsigned byte_pos = 0;
    int unsigned first_off = 0;
    int unsigned last_off = 0;
    bit          err_seen = 1'b0;
    int unsigned err_off = 0;

    function automatic bit is_space(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_VT || c == CH_FF ||
               c == CH_CR;
    endfunction

    function automatic bit is_b64_char(logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || (c >= "0" && c <= "9") ||
               c == CH_PLUS || c == CH_SLASH;
    endfunction

    function automatic void clear_scan();
        scan_phase = SCAN_LEAD;
        data_cnt = 0;
        pad_cnt = 0;
        byte_pos = 0;
        first_off = 0;
        last_off = 0;
        err_seen = 1'b0;
        err_off = 0;
    endfunction

    function automatic void stop_scan(int unsigned pos, bit ws);
        scan_phase = SCAN_STOP;
        err_off = pos;
        if (!ws) begin
            err_seen = 1'b1;
        end
    endfunction

    // Advances the scan by one beat and queues the result when the value ends.
    function automatic void scan_text_beat(t_in_item beat);
        int unsigned pos;
        bit          ws;
        int unsigned total;
        int unsigned decoded;
        t_result     res;
        if (!beat.empty_value) begin
            pos = byte_pos;
            ws = is_space(beat.text_byte);
            if (byte_pos >= MAX_TEXT_LEN_DEF) begin
                byte_pos = MAX_TEXT_LEN_DEF + 1;
            end else begin
                byte_pos = pos + 1;
                if (!ws) begin
                    last_off = pos + 1;
                end
                if (scan_phase == SCAN_LEAD && !ws) begin
                    first_off = pos;
                    scan_phase = SCAN_DATA;
                end
                case (scan_phase)
                    SCAN_DATA: begin
                        if (is_b64_char(beat.text_byte)) begin
                            data_cnt++;
                        end else if (beat.text_byte == CH_PAD) begin
                            scan_phase = SCAN_PAD;
                            pad_cnt = 1;
                        end else if (beat.text_byte != CH_LF) begin
                            stop_scan(pos, ws);
                        end
                    end
                    SCAN_PAD: begin
                        if (beat.text_byte == CH_PAD && pad_cnt < 2) begin
                            pad_cnt++;
                        end else if (!(beat.text_byte == CH_LF && pad_cnt < 2)) begin
                            stop_scan(pos, ws);
                        end
                    end
                    SCAN_STOP: begin
                        if (!ws) begin
                            err_seen = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        if (beat.empty_value || beat.last_byte) begin
            res = '0;
            res.status = ST_OK;
            total = data_cnt + pad_cnt;
            if (byte_pos > MAX_TEXT_LEN_DEF) begin
                res.status = ST_LONG;
            end else begin
                res.trim_start = (scan_phase == SCAN_LEAD) ? byte_pos[15:0] : first_off[15:0];
                res.trim_end = (scan_phase == SCAN_LEAD) ? byte_pos[15:0] : last_off[15:0];
                if (err_seen) begin
                    res.status = ST_BAD;
                    res.bad_offset = err_off[15:0];
                end else if (total % 4 != 0) begin
                    res.status = ST_COUNT;
                end else begin
                    decoded = (total / 4) * 3 - pad_cnt;
                    res.decoded_octets = (decoded > 65535) ? 16'hFFFF : decoded[15:0];
                    if (cfg_len_en && (decoded < cfg_min || decoded > cfg_max)) begin
                        res.status = ST_RANGE;
                    end
                end
            end
            pending_results.push_back(res);
            clear_scan();
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                scan_text_beat(i_item);
                beats_taken++;
            end
            if (!push || !full) begin
                if (text_beats.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    push <= 1'b1;
                    i_item <= text_beats.pop_front();
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result beat: status %0d octets %0d", o_result.status,
                                 o_result.decoded_octets);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.status !== want.status ||
                        o_result.decoded_octets !== want.decoded_octets ||
                        o_result.trim_start !== want.trim_start ||
                        o_result.trim_end !== want.trim_end ||
                        o_result.bad_offset !== want.bad_offset) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                                     want.status, want.decoded_octets, want.trim_start,
                                     want.trim_end, want.bad_offset, o_result.status,
                                     o_result.decoded_octets, o_result.trim_start,
                                     o_result.trim_end, o_result.bad_offset);
                        end
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else if (holds_served != holds_asked) begin
                holds_served++;
                hold_left = HOLD_CYCLES;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic add_beat(logic [7:0] c, logic last, logic emp);
        t_in_item b;
        b.text_byte = c;
        b.last_byte = last;
        b.empty_value = emp;
        text_beats.push_back(b);
        beats_queued++;
    endtask

    task automatic add_text(string s);
        if (s.len() == 0) begin
            add_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
            for (int i = 0; i < s.len(); i++) begin
                add_beat(s[i], i == s.len() - 1, 1'b0);
            end
        end
    endtask

    function automatic logic [7:0] rand_space();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_VT;
            4: return CH_FF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_b64_char();
        int unsigned k;
        k = $urandom_range(63);
        if (k < 26) return 8'("A" + k);
        if (k < 52) return 8'("a" + k - 26);
        if (k < 62) return 8'("0" + k - 52);
        if (k == 62) return CH_PLUS;
        return CH_SLASH;
    endfunction

    // Mostly well-formed values with random content, the rest broken or plain noise.
    task automatic add_random_value();
        logic [7:0]  v[$];
        int unsigned kind;
        int unsigned quads;
        int unsigned pads;
        kind = $urandom_range(99);
        quads = ($urandom_range(9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
        pads = (quads == 0) ? 0 : $urandom_range(2);
        repeat ($urandom_range(2)) v.push_back(rand_space());
        for (int i = 0; i < quads * 4 - pads; i++) begin
            v.push_back(rand_b64_char());
            if ($urandom_range(9) == 0) v.push_back(CH_LF);
        end
        for (int i = 0; i < pads; i++) begin
            if ($urandom_range(3) == 0) v.push_back(CH_LF);
            v.push_back(CH_PAD);
        end
        repeat ($urandom_range(2)) v.push_back(rand_space());
        if (kind >= 70 && kind < 78) begin
            v.insert($urandom_range(v.size()), rand_b64_char());
        end else if (kind >= 78 && kind < 86 && v.size() != 0) begin
            v[$urandom_range(v.size() - 1)] = 8'($urandom_range(255));
        end else if (kind >= 86 && kind < 90) begin
            v.insert($urandom_range(v.size()), rand_space());
            v.push_back(rand_b64_char());
        end else if (kind >= 90 && kind < 94) begin
            v.push_back(CH_PAD);
            if ($urandom_range(1)) v.push_back(rand_b64_char());
        end else if (kind >= 94 && kind < 97) begin
            v.delete();
            repeat ($urandom_range(1, 10)) v.push_back(8'($urandom_range(255)));
        end
        if (kind >= 97 || v.size() == 0) begin
            foreach (v[i]) add_beat(v[i], 1'b0, 1'b0);
            add_beat(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
        end else begin
            foreach (v[i]) add_beat(v[i], i == v.size() - 1, 1'b0);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(logic en, logic [15:0] lo, logic [15:0] hi);
        write_reg(REG_LEN_EN, {31'd0, en});
        cfg_len_en = en;
        write_reg(REG_MIN, {16'd0, lo});
        cfg_min = lo;
        write_reg(REG_MAX, {16'd0, hi});
        cfg_max = hi;
    endtask

    task automatic settle();
        while (beats_taken != beats_queued || pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #4000000;
        $display("base64_text_validator_test NOT OK");
        $finish;
    end

    initial begin
        int unsigned target;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        set_config(1'b0, 16'd0, 16'hFFFF);
        add_text("");
        add_text("QQ==");
        add_text("QUI=");
        add_text("+/09azAZ");
        add_beat(CH_CR, 1'b0, 1'b0);
        add_beat(CH_VT, 1'b0, 1'b0);
        add_beat(CH_FF, 1'b0, 1'b0);
        add_text(" \tQU\nJD\n");
        add_text("QQ=\n=");
        add_text("QQ===");
        add_text("QU JD");
        add_text("QUJD \t");
        add_text("QUJ");
        add_text("   ");
        add_text("Q!JD");
        add_text("=");
        add_text("QU\n\n");
        add_beat(8'h00, 1'b1, 1'b0);
        add_beat(8'hFF, 1'b1, 1'b0);
        add_beat("Q", 1'b0, 1'b0);
        add_beat("U", 1'b0, 1'b0);
        add_beat("J", 1'b0, 1'b0);
        add_beat("D", 1'b0, 1'b0);
        add_beat(8'hA5, 1'b0, 1'b1);
        settle();

        set_config(1'b1, 16'd4, 16'd6);
        add_text("QUJD");
        add_text("QUJDRA==");
        add_text("QUJDRUZH");
        add_text("QUJDRUZHSA==");
        add_text("");
        settle();
        set_config(1'b1, 16'd9, 16'd2);
        add_text("QUJDRUZH");
        settle();

        // Longest accepted value, then one byte more than the limit.
        set_config(1'b1, 16'd49149, 16'd49149);
        for (int i = 0; i < 65532; i++) add_beat("A", 1'b0, 1'b0);
        add_beat(CH_LF, 1'b0, 1'b0);
        add_beat(CH_LF, 1'b0, 1'b0);
        add_beat(CH_LF, 1'b1, 1'b0);
        for (int i = 0; i < 65536; i++) add_beat("A", i == 65535, 1'b0);
        settle();

        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin sender_idle_pct = 15; recv_stall_pct = 15; end
            endcase
            case (p)
                0: set_config(1'b0, 16'd0, 16'hFFFF);
                1: set_config(1'b1, 16'd0, 16'hFFFF);
                3: set_config(1'b1, 16'hFFFF, 16'hFFFF);
                5: set_config(1'b1, 16'd0, 16'd0);
                6: set_config(1'b1, 16'd20, 16'd3);
                default: set_config(1'($urandom_range(1)), 16'($urandom_range(0, 6)),
                                    16'($urandom_range(3, 20)));
            endcase
            if (p == 4) holds_asked++;
            target = beats_queued + RANDOM_BEATS_PER_PHASE;
            while (beats_queued < target) add_random_value();
            settle();
        end

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("base64_text_validator_test OK");
        end else begin
            $display("base64_text_validator_test NOT OK");
        end
        $finish;
    end

endmodule
